@@ sv/rwte_pkg.sv @@
// ----------------------------------------------------------------------------
// rwte_pkg
// Shared types and constants for the sliding-window RTT timer estimator:
// field widths, configuration register indexes and the controller interface.
// ----------------------------------------------------------------------------
package rwte_pkg;

    localparam int RTT_W      = 32;   // sample and result field width
    localparam int WLEN_W     = 7;    // window_length register width
    localparam int FRAC_W     = 16;   // fraction bits of the threshold
    localparam int THR_W      = FRAC_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 2'd1;

    localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd64;
    localparam logic [THR_W-1:0]  THR_RESET  = 17'd32768;
    localparam logic [THR_W-1:0]  THR_ONE    = 17'h10000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // take the accepted sample into the work register
        logic append;      // write the sample into the ring and update the window
        logic read_issue;  // read one ring entry for the min/max scan
        logic mult;        // multiply the span by the threshold
        logic add;         // form the timer estimate
        logic load_out;    // move the result into the output register
    } rwte_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;   // the entry being read is the last one held
        logic out_free;    // the output register can take a new word
    } rwte_stat_t;

endpackage

@@ sv/rwte_ctrl.sv @@
// ----------------------------------------------------------------------------
// rwte_ctrl
// Sequencer for one sample: capture, ring append, scan of the held samples,
// multiply, add, and hand-off to the output register.
// ----------------------------------------------------------------------------
module rwte_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rwte_pkg::rwte_stat_t stat,
    output rwte_pkg::rwte_cmd_t  cmd
);
    import rwte_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_APPEND = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_LAST   = 3'd3;
    localparam logic [2:0] ST_MULT   = 3'd4;
    localparam logic [2:0] ST_ADD    = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND: begin
                cmd.append = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.read_issue = 1'b1;
                if (stat.scan_last) begin
                    state_next = ST_LAST;
                end
            end
            // The last read word is compared in this cycle.
            ST_LAST: begin
                state_next = ST_MULT;
            end
            ST_MULT: begin
                cmd.mult   = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                cmd.add    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ sv/rwte_datapath.sv @@
// ----------------------------------------------------------------------------
// rwte_datapath
// Sample ring, window pointers, configuration registers, min/max scan,
// estimate arithmetic and the output register.
// ----------------------------------------------------------------------------
module rwte_datapath #(
    parameter int WINDOW_DEPTH = 64,
    parameter int SAMPLE_BITS  = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [rwte_pkg::RTT_W-1:0]       s_rtt_sample,
    input  logic                             cfg_write,
    input  logic [rwte_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rwte_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  rwte_pkg::rwte_cmd_t              cmd,
    output rwte_pkg::rwte_stat_t             stat,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [rwte_pkg::RTT_W-1:0]       m_window_min,
    output logic [rwte_pkg::RTT_W-1:0]       m_window_max,
    output logic [rwte_pkg::RTT_W-1:0]       m_timer_estimate
);
    import rwte_pkg::*;

    localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int LEN_W  = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
    // Samples arrive on a fixed-width port, so bits above it are always zero.
    localparam int DATA_W = (SAMPLE_BITS < RTT_W) ? SAMPLE_BITS : RTT_W;
    localparam int PROD_W = DATA_W + THR_W;

    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(WINDOW_DEPTH - 1);
    localparam logic [CNT_W:0]   DEPTH_EXT = (CNT_W + 1)'(WINDOW_DEPTH);
    localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(WINDOW_DEPTH);

    logic [DATA_W-1:0] ring [WINDOW_DEPTH];

    logic [WLEN_W-1:0] wlen_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [IDX_W-1:0]  oldest_reg;
    logic [CNT_W-1:0]  held_reg;
    logic [IDX_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  scan_cnt_reg;
    logic              rd_valid_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic [DATA_W-1:0] sample_reg;
    logic [DATA_W-1:0] lo_reg;
    logic [DATA_W-1:0] hi_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [DATA_W-1:0] est_reg;
    logic              m_valid_reg;
    logic [DATA_W-1:0] out_min_reg;
    logic [DATA_W-1:0] out_max_reg;
    logic [DATA_W-1:0] out_est_reg;

    logic [LEN_W-1:0]  len_wide;
    logic [CNT_W-1:0]  eff_len;
    logic [CNT_W:0]    slot_sum;
    logic [CNT_W:0]    slot_wrap;
    logic [IDX_W-1:0]  slot;
    logic [CNT_W:0]    held_inc;
    logic              over;
    logic [IDX_W-1:0]  oldest_inc;
    logic [IDX_W-1:0]  oldest_next;
    logic [IDX_W-1:0]  rd_ptr_inc;
    logic [THR_W-1:0]  thr_sat;

    // Effective window length: zero means one, and it never exceeds the ring.
    always_comb begin
        len_wide = LEN_W'(wlen_reg);
        if (wlen_reg == '0) begin
            len_wide = LEN_W'(1);
        end else if (len_wide > DEPTH_LEN) begin
            len_wide = DEPTH_LEN;
        end
        eff_len = len_wide[CNT_W-1:0];
    end

    // The sum stays below twice the depth, so one conditional subtract wraps the slot.
    assign slot_sum  = (CNT_W + 1)'(oldest_reg) + (CNT_W + 1)'(held_reg);
    assign slot_wrap = (slot_sum >= DEPTH_EXT) ? (slot_sum - DEPTH_EXT) : slot_sum;
    assign slot      = slot_wrap[IDX_W-1:0];

    assign held_inc    = (CNT_W + 1)'(held_reg) + (CNT_W + 1)'(1);
    assign over        = held_inc > (CNT_W + 1)'(eff_len);
    assign oldest_inc  = (oldest_reg == IDX_LAST) ? '0 : oldest_reg + IDX_W'(1);
    assign oldest_next = over ? oldest_inc : oldest_reg;
    assign rd_ptr_inc  = (rd_ptr_reg == IDX_LAST) ? '0 : rd_ptr_reg + IDX_W'(1);
    assign thr_sat     = thr_reg[THR_W-1] ? THR_ONE : thr_reg;

    assign stat.scan_last = ((CNT_W + 1)'(scan_cnt_reg) + (CNT_W + 1)'(1))
                            == (CNT_W + 1)'(held_reg);
    assign stat.out_free  = !m_valid_reg || m_ready;

    // Control state and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg     <= WLEN_RESET;
            thr_reg      <= THR_RESET;
            oldest_reg   <= '0;
            held_reg     <= '0;
            rd_ptr_reg   <= '0;
            scan_cnt_reg <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.read_issue;
            if (cmd.append) begin
                oldest_reg   <= oldest_next;
                held_reg     <= over ? held_reg : held_inc[CNT_W-1:0];
                rd_ptr_reg   <= oldest_next;
                scan_cnt_reg <= '0;
            end
            if (cmd.read_issue) begin
                rd_ptr_reg   <= rd_ptr_inc;
                scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
            end
            if (cfg_write) begin
                if (cfg_index == REG_WINDOW_LENGTH) begin
                    wlen_reg   <= cfg_data[WLEN_W-1:0];
                    oldest_reg <= '0;
                    held_reg   <= '0;
                end else if (cfg_index == REG_THRESHOLD) begin
                    thr_reg <= cfg_data[THR_W-1:0];
                end
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Sample ring: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.append) begin
            ring[slot] <= sample_reg;
        end
        if (cmd.read_issue) begin
            rd_data_reg <= ring[rd_ptr_reg];
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sample_reg <= s_rtt_sample[DATA_W-1:0];
        end
        if (cmd.append) begin
            lo_reg <= sample_reg;
            hi_reg <= sample_reg;
        end else if (rd_valid_reg) begin
            if (rd_data_reg < lo_reg) begin
                lo_reg <= rd_data_reg;
            end
            if (rd_data_reg > hi_reg) begin
                hi_reg <= rd_data_reg;
            end
        end
        if (cmd.mult) begin
            prod_reg <= PROD_W'(hi_reg - lo_reg) * PROD_W'(thr_sat);
        end
        // The scaled span never exceeds the span, so the sum stays in range.
        if (cmd.add) begin
            est_reg <= lo_reg + prod_reg[DATA_W+FRAC_W-1:FRAC_W];
        end
        if (cmd.load_out) begin
            out_min_reg <= lo_reg;
            out_max_reg <= hi_reg;
            out_est_reg <= est_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_window_min     = RTT_W'(out_min_reg);
    assign m_window_max     = RTT_W'(out_max_reg);
    assign m_timer_estimate = RTT_W'(out_est_reg);

endmodule

@@ sv/rtt_window_timer_estimator_top.sv @@
// ----------------------------------------------------------------------------
// rtt_window_timer_estimator_top
// Sliding-window min/max of round-trip-time samples with a timeout estimate
// min + ((max - min) * threshold) >> 16.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one rtt_sample word per item. m_ channel: one result word per
//   item carrying window_min, window_max and timer_estimate. cfg channel:
//   cfg_index 0 writes window_length (and empties the window), cfg_index 1
//   writes threshold_fraction; cfg_ready is always high. Writes must be
//   made only while no item is in flight; the block does not enforce this.
//   An item passes from acceptance through the append, a scan of the N
//   samples held after the append (1 up to the window length), the compare
//   of the last word read, the multiply and the add before the result is
//   offered. The next sample is accepted once the result has moved into
//   the output register. The scan reads one ring entry per cycle through
//   the single read port of the sample ring. One item is processed at a
//   time.
//   Reset empties the window and restores window_length 64 and threshold
//   0.5; no clearing pass is needed. A stalled receiver holds the result in
//   the output register; the next sample is still accepted and processed,
//   and waits before the output register until the previous word is taken.
// ----------------------------------------------------------------------------
module rtt_window_timer_estimator_top #(
    parameter int WINDOW_DEPTH = 64,
    parameter int SAMPLE_BITS  = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [rwte_pkg::RTT_W-1:0]       s_rtt_sample,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [rwte_pkg::RTT_W-1:0]       m_window_min,
    output logic [rwte_pkg::RTT_W-1:0]       m_window_max,
    output logic [rwte_pkg::RTT_W-1:0]       m_timer_estimate,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rwte_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rwte_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rwte_pkg::*;

    rwte_cmd_t  cmd;
    rwte_stat_t stat;

    assign cfg_ready = 1'b1;

    rwte_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rwte_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_rtt_sample     (s_rtt_sample),
        .cfg_write        (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .stat             (stat),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_window_min     (m_window_min),
        .m_window_max     (m_window_max),
        .m_timer_estimate (m_timer_estimate)
    );

    // Only one step of the sequence is commanded in any cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.capture, cmd.append, cmd.read_issue, cmd.mult, cmd.add,
                  cmd.load_out}))
        else $error("more than one datapath command active");

    // An accepted word closes the input until its result is moved into the output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an item is in progress");

    // A waiting result is never overwritten.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid || m_ready))
        else $error("output register loaded while a word is pending");

    // The estimate always lies between the window minimum and maximum.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_window_min <= m_timer_estimate &&
                     m_timer_estimate <= m_window_max))
        else $error("timer estimate outside the window range");

endmodule

@@ tb/sv/rtt_window_timer_estimator_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rtt_window_timer_estimator_top_test
// Self-checking bench for the sliding-window RTT timer estimator. The
// scoreboard keeps its own copy of the sample window and the register
// settings. It predicts min, max and timer estimate for every accepted
// sample and compares each result word against the oldest prediction.
// A directed section covers field extremes and register corner values.
// Random runs follow under several idle and stall patterns.
// ----------------------------------------------------------------------------
module rtt_window_timer_estimator_top_test;
    import rwte_pkg::*;

    localparam int RING_DEPTH      = 64;
    localparam int HOLD_OFF_CYCLES = 400;
    // Index 2 is not decoded by the block, so a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;

    typedef struct {
        logic [RTT_W-1:0] lo;
        logic [RTT_W-1:0] hi;
        logic [RTT_W-1:0] estimate;
    } window_result_t;

    class window_scoreboard;
        logic [RTT_W-1:0]  ring [RING_DEPTH];
        logic [5:0]        oldest;
        logic [6:0]        held;
        logic [WLEN_W-1:0] window_length;
        logic [THR_W-1:0]  threshold;
        window_result_t    pending_results[$];
        int                mismatches;

        function new();
            oldest        = '0;
            held          = '0;
            window_length = WLEN_RESET;
            threshold     = THR_RESET;
            mismatches    = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_WINDOW_LENGTH) begin
                window_length = data[WLEN_W-1:0];
                oldest        = '0;
                held          = '0;
            end else if (idx == REG_THRESHOLD) begin
                threshold = data[THR_W-1:0];
            end
        endfunction

        function void note_sample(logic [RTT_W-1:0] sample);
            logic [6:0]       limit;
            logic [RTT_W-1:0] v;
            logic [THR_W-1:0] frac;
            logic [63:0]      span_scaled;
            window_result_t   r;
            limit = window_length;
            if (limit == 7'd0)
                limit = 7'd1;
            if (limit > 7'(RING_DEPTH))
                limit = 7'(RING_DEPTH);
            ring[6'(oldest + held)] = sample;
            held++;
            // The window is emptied whenever its length changes, so at most one drop.
            if (held > limit) begin
                oldest++;
                held--;
            end
            r.lo = sample;
            r.hi = sample;
            for (int i = 0; i < held; i++) begin
                v = ring[6'(oldest + i)];
                if (v < r.lo)
                    r.lo = v;
                if (v > r.hi)
                    r.hi = v;
            end
            frac        = (threshold > THR_ONE) ? THR_ONE : threshold;
            span_scaled = (64'(r.hi - r.lo) * 64'(frac)) >> FRAC_W;
            r.estimate  = r.lo + span_scaled[RTT_W-1:0];
            pending_results = {pending_results, r};
        endfunction

        task report_mismatch(string what);
            if (mismatches < 100)
                $display("[%0t ns] mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_result(logic [RTT_W-1:0] lo, logic [RTT_W-1:0] hi,
                          logic [RTT_W-1:0] estimate);
            window_result_t want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result min %h max %h est %h with no sample waiting",
                                          lo, hi, estimate));
                return;
            end
            want = pending_results[0];
            pending_results.delete(0);
            if (lo !== want.lo)
                report_mismatch($sformatf("window_min %h, expected %h", lo, want.lo));
            if (hi !== want.hi)
                report_mismatch($sformatf("window_max %h, expected %h", hi, want.hi));
            if (estimate !== want.estimate)
                report_mismatch($sformatf("timer_estimate %h, expected %h",
                                          estimate, want.estimate));
        endtask
    endclass

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [RTT_W-1:0]      s_rtt_sample = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [RTT_W-1:0]      m_window_min;
    logic [RTT_W-1:0]      m_window_max;
    logic [RTT_W-1:0]      m_timer_estimate;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_off_req   = 1'b0;

    window_scoreboard sb = new();

    rtt_window_timer_estimator_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rtt_sample     (s_rtt_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_window_min     (m_window_min),
        .m_window_max     (m_window_max),
        .m_timer_estimate (m_timer_estimate),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_sample(s_rtt_sample);
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_window_min, m_window_max, m_timer_estimate);
    end

    // Result side: random stalls, plus one long hold-off on request.
    always begin : receiver
        @(posedge aclk);
        if (hold_off_req) begin
            hold_off_req = 1'b0;
            m_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge aclk);
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [RTT_W-1:0] random_rtt();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return 32'd1 << $urandom_range(31);
            3, 4:    return $urandom_range(100, 2000);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [WLEN_W-1:0] pick_window();
        case ($urandom_range(5))
            0:       return WLEN_W'($urandom_range(1, 4));
            1:       return 7'd64;
            2:       return WLEN_W'($urandom_range(65, 127));
            3:       return 7'd0;
            default: return WLEN_W'($urandom_range(5, 63));
        endcase
    endfunction

    function automatic logic [THR_W-1:0] pick_threshold();
        case ($urandom_range(4))
            0:       return '0;
            1:       return THR_ONE;
            2:       return THR_W'($urandom_range(65537, 131071));
            3:       return 17'd65535;
            default: return THR_W'($urandom_range(1, 65535));
        endcase
    endfunction

    // Leaves cfg_valid high so that back-to-back writes need no toggle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic set_window(input logic [WLEN_W-1:0] wlen, input logic [THR_W-1:0] thr);
        write_reg(REG_WINDOW_LENGTH, {10'($urandom()), wlen});
        write_reg(REG_THRESHOLD, thr);
        cfg_valid <= 1'b0;
    endtask

    // Leaves s_valid high after the word is taken; the next call or a drain decides.
    task automatic send_sample(input logic [RTT_W-1:0] value);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid      <= 1'b1;
        s_rtt_sample <= value;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_run(input int count);
        repeat (count) send_sample(random_rtt());
    endtask

    task automatic stop_and_drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
        repeat (8) @(posedge aclk);
    endtask

    initial begin : stimulus
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: full 64-entry window, half-span threshold.
        send_sample(32'h0000_0000);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h0000_0001);
        send_sample(32'hFFFF_FFFE);
        stop_and_drain();

        // Full-span threshold: the estimate lands on the maximum.
        set_window(7'd2, THR_ONE);
        send_sample(32'h0000_0000);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_0010);
        stop_and_drain();

        // A zero window length behaves as one; zero threshold gives the minimum.
        set_window(7'd0, 17'd0);
        send_sample(32'h0000_0007);
        send_sample(32'h0000_0009);
        stop_and_drain();

        set_window(7'd1, 17'h08000);
        send_sample(32'hAAAA_AAAA);
        send_sample(32'h5555_5555);
        stop_and_drain();

        // Oversized length saturates to the ring depth, oversized threshold to one.
        set_window(7'd127, 17'h1FFFF);
        send_sample(32'h0000_1000);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_0000);
        stop_and_drain();

        // A threshold write keeps the samples already in the window.
        write_reg(REG_THRESHOLD, 17'd65535);
        cfg_valid <= 1'b0;
        send_sample(32'h0000_0020);
        stop_and_drain();

        write_reg(REG_SPARE, '1);
        cfg_valid <= 1'b0;
        send_sample(32'h0000_0005);
        stop_and_drain();

        set_window(7'd2, 17'd1);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_0000);
        send_sample(32'h1234_5678);
        stop_and_drain();

        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 49;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 49;
                end
                default: begin
                    send_idle_pct  = 14;
                    recv_stall_pct = 14;
                end
            endcase
            for (int seg = 0; seg < 4; seg++) begin
                set_window(pick_window(), pick_threshold());
                // With the receiver held off the block fills and must stall its input.
                if (mode == 0 && seg == 1)
                    hold_off_req = 1'b1;
                send_run(23);
                if (mode == 1 && seg == 2)
                    stop_and_drain();
                send_run(23);
                stop_and_drain();
            end
        end

        repeat (80) @(posedge aclk);
        @(negedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // The timeout lies far beyond the length of a slow correct run.
    initial begin : watchdog
        #15_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
